// ===== hw/rtl/swmr_pkg.sv =====
// Shared types, sizes and helpers for the sliding window max-minus-min block.
// No dependencies; every other file of the block but swmr_ram imports this package.
package swmr_pkg;

  localparam int SAMPLE_W    = 32;
  localparam int OUT_W       = 32;
  localparam int GAP_W       = 8;
  localparam int MAX_WINDOW  = 256;
  localparam int ADDR_W      = $clog2(MAX_WINDOW);
  // Deque pointers and sample indices carry one extra wrap bit.
  localparam int PTR_W       = ADDR_W + 1;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QUEUE_AW + 1;

  // One queued request: sample already biased so unsigned order is signed order.
  typedef struct packed {
    logic [SAMPLE_W-1:0] value;
    logic                first;
    logic                last;
  } item_t;

  // One deque entry: index of the sample within its sequence, and its value.
  typedef struct packed {
    logic [PTR_W-1:0]    idx;
    logic [SAMPLE_W-1:0] value;
  } deque_entry_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] value;
    logic                first;
  } eng_cmd_t;

  typedef struct packed {
    logic                done;
    logic [SAMPLE_W-1:0] value;
  } eng_stat_t;

  // Window length is the gap plus two, capped at the store depth.
  function automatic logic [PTR_W-1:0] win_len(input logic [GAP_W-1:0] gap);
    logic [GAP_W+1:0] full;
    full = {2'b00, gap} + (GAP_W+2)'(2);
    if (full > (GAP_W+2)'(MAX_WINDOW)) begin
      return PTR_W'(MAX_WINDOW);
    end
    return PTR_W'(full);
  endfunction

endpackage

// ===== hw/rtl/swmr_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module swmr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/swmr_front.sv =====
// Front end: takes input requests, biases the sample and queues them.
// Depends on swmr_pkg.
module swmr_front import swmr_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [SAMPLE_W-1:0] s_tdata,
  input  logic                s_tuser,
  input  logic                s_tlast,
  output logic                q_valid,
  output item_t               q_item,
  input  logic                q_pop
);

  item_t               slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic                push;
  logic                pop;
  item_t               in_item;

  assign s_tready = (count != QCNT_W'(QUEUE_DEPTH));
  assign push     = s_tvalid && s_tready;
  assign q_valid  = (count != '0);
  assign pop      = q_pop && q_valid;
  assign q_item   = slots[rd_ptr];

  // Flipping the sign bit turns signed order into unsigned order.
  assign in_item.value = s_tdata ^ {1'b1, {(SAMPLE_W-1){1'b0}}};
  assign in_item.first = s_tuser;
  assign in_item.last  = s_tlast;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hw/rtl/swmr_deque.sv =====
// Back-end monotone deque engine: tracks the window maximum (or minimum)
// with a deque held in a swmr_ram instance. Depends on swmr_pkg, swmr_ram.
module swmr_deque import swmr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             find_min,
  input  logic             rewind,
  input  logic [PTR_W-1:0] window_len,
  input  logic             start,
  input  eng_cmd_t         cmd,
  output eng_stat_t        stat
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_FRONT  = 3'd1;
  localparam logic [2:0] ST_BACK   = 3'd2;
  localparam logic [2:0] ST_REFILL = 3'd3;
  localparam logic [2:0] ST_VIEW   = 3'd4;

  logic [2:0]          state, state_next;
  logic [PTR_W-1:0]    head, head_next;
  logic [PTR_W-1:0]    tail, tail_next;
  logic [PTR_W-1:0]    view, view_next;
  logic [PTR_W-1:0]    seq_cnt, seq_cnt_next;
  logic [PTR_W-1:0]    cur, cur_next;
  logic [SAMPLE_W-1:0] val, val_next;
  logic [SAMPLE_W-1:0] back_val, back_val_next;
  logic [SAMPLE_W-1:0] res_val, res_val_next;
  logic                done, done_next;

  logic                we;
  logic [PTR_W-1:0]    rd_ptr;
  deque_entry_t        wr_entry;
  deque_entry_t        rd_entry;
  logic [PTR_W-1:0]    age;
  logic                empty;
  logic                dominated;

  swmr_ram #(
    .WIDTH ($bits(deque_entry_t)),
    .DEPTH (MAX_WINDOW)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (tail[ADDR_W-1:0]),
    .wdata (wr_entry),
    .raddr (rd_ptr[ADDR_W-1:0]),
    .rdata (rd_entry)
  );

  assign empty    = (head == tail);
  assign age      = cur - rd_entry.idx;
  assign wr_entry = '{idx: cur, value: val};
  // The back entry can never matter again once the new sample beats or ties it.
  assign dominated = find_min ? (back_val >= val) : (back_val <= val);

  assign stat.done  = done;
  assign stat.value = res_val;

  always_comb begin
    state_next    = state;
    head_next     = head;
    tail_next     = tail;
    view_next     = view;
    seq_cnt_next  = seq_cnt;
    cur_next      = cur;
    val_next      = val;
    back_val_next = back_val;
    res_val_next  = res_val;
    done_next     = 1'b0;
    we            = 1'b0;
    rd_ptr        = view;
    unique case (state)
      ST_IDLE: begin
        // A new window length may reach back past entries the view already left.
        if (rewind) begin
          view_next = head;
        end
        if (start) begin
          val_next = cmd.value;
          if (cmd.first) begin
            head_next  = '0;
            tail_next  = '0;
            view_next  = '0;
            cur_next   = '0;
            state_next = ST_BACK;
          end else begin
            cur_next = seq_cnt;
            if (empty) begin
              state_next = ST_BACK;
            end else begin
              rd_ptr     = head;
              state_next = ST_FRONT;
            end
          end
        end
      end
      ST_FRONT: begin
        // At most the oldest entry can have left the store span.
        if (age[PTR_W-1]) begin
          head_next = head + 1'b1;
          if (view == head) begin
            view_next = head + 1'b1;
          end
        end
        state_next = ST_BACK;
      end
      ST_BACK: begin
        if (!empty && dominated) begin
          tail_next = tail - 1'b1;
          if (view == tail) begin
            view_next = tail - 1'b1;
          end
          rd_ptr = tail - PTR_W'(2);
          if ((tail - 1'b1) != head) begin
            state_next = ST_REFILL;
          end
        end else begin
          we            = 1'b1;
          tail_next     = tail + 1'b1;
          back_val_next = val;
          if (view == tail) begin
            done_next    = 1'b1;
            res_val_next = val;
            seq_cnt_next = cur + 1'b1;
            state_next   = ST_IDLE;
          end else begin
            state_next = ST_VIEW;
          end
        end
      end
      ST_REFILL: begin
        back_val_next = rd_entry.value;
        state_next    = ST_BACK;
      end
      ST_VIEW: begin
        if (age >= window_len) begin
          view_next = view + 1'b1;
          if ((view + 1'b1) == (tail - 1'b1)) begin
            done_next    = 1'b1;
            res_val_next = val;
            seq_cnt_next = cur + 1'b1;
            state_next   = ST_IDLE;
          end else begin
            rd_ptr = view + 1'b1;
          end
        end else begin
          done_next    = 1'b1;
          res_val_next = rd_entry.value;
          seq_cnt_next = cur + 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      head    <= '0;
      tail    <= '0;
      view    <= '0;
      seq_cnt <= '0;
      done    <= 1'b0;
    end else begin
      state   <= state_next;
      head    <= head_next;
      tail    <= tail_next;
      view    <= view_next;
      seq_cnt <= seq_cnt_next;
      done    <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    cur      <= cur_next;
    val      <= val_next;
    back_val <= back_val_next;
    res_val  <= res_val_next;
  end

endmodule

// ===== hw/rtl/sliding_window_max_range.sv =====
// Top level of the sliding window max-minus-min block: front queue, two deque
// engines, spread tracking and output register. Depends on swmr_pkg,
// swmr_front, swmr_deque.
//
//   channel  direction  signals                    content
//   s_*      in         tvalid tready tdata tuser  sample, first flag, last flag
//                       tlast
//   m_*      out        tvalid tready tdata tlast  best spread, final flag
//   cfg_*    in         valid ready data           window_gap register
//
// A back-end request that opens a sequence or finds the deque empty goes straight
// to the back of the deque; any other request first checks the front entry's age.
// Each entry dropped from the back of a deque costs a refill read unless it leaves
// the deque empty, and the window view then reads older entries, both skipped
// entries and the one that gives the answer. The slower of the maximum and minimum
// engines sets the pace. Reset clears all control state; deque and queue storage
// is not cleared. Up to four requests wait in the front queue while the back end or
// the output stalls, and a result waiting in the output register does not stop new
// requests from being taken into the queue.
module sliding_window_max_range import swmr_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [SAMPLE_W-1:0] s_tdata,   // [31:0] sample
  input  logic                s_tuser,   // [0] first_of_sequence
  input  logic                s_tlast,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [OUT_W-1:0]    m_tdata,   // [31:0] best_spread
  output logic                m_tlast,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [GAP_W-1:0]    cfg_data
);

  localparam logic [1:0] TS_IDLE = 2'd0;
  localparam logic [1:0] TS_RUN  = 2'd1;
  localparam logic [1:0] TS_OUT  = 2'd2;

  logic [1:0]          tstate;
  logic [GAP_W-1:0]    window_gap;
  logic                q_valid;
  item_t               q_item;
  logic                q_pop;
  logic                start;
  eng_cmd_t            cmd;
  eng_stat_t           max_stat;
  eng_stat_t           min_stat;
  logic                rewind;
  logic [PTR_W-1:0]    window_len;
  logic                got_max;
  logic                got_min;
  logic [SAMPLE_W-1:0] max_val;
  logic [SAMPLE_W-1:0] min_val;
  logic [OUT_W-1:0]    spread;
  logic [OUT_W-1:0]    best;
  logic [OUT_W-1:0]    best_base;
  logic [OUT_W-1:0]    best_next;
  logic                item_first;
  logic                item_last;
  logic                out_free;

  assign cfg_ready  = 1'b1;
  assign rewind     = cfg_valid && cfg_ready;
  assign window_len = win_len(window_gap);

  swmr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  assign start     = (tstate == TS_IDLE) && q_valid;
  assign q_pop     = start;
  assign cmd.value = q_item.value;
  assign cmd.first = q_item.first;

  swmr_deque u_max (
    .clk        (clk),
    .rst        (rst),
    .find_min   (1'b0),
    .rewind     (rewind),
    .window_len (window_len),
    .start      (start),
    .cmd        (cmd),
    .stat       (max_stat)
  );

  swmr_deque u_min (
    .clk        (clk),
    .rst        (rst),
    .find_min   (1'b1),
    .rewind     (rewind),
    .window_len (window_len),
    .start      (start),
    .cmd        (cmd),
    .stat       (min_stat)
  );

  assign out_free  = !m_tvalid || m_tready;
  assign best_base = item_first ? '0 : best;
  assign best_next = (spread > best_base) ? spread : best_base;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_gap <= '0;
    end else if (rewind) begin
      window_gap <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tstate   <= TS_IDLE;
      got_max  <= 1'b0;
      got_min  <= 1'b0;
      best     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (max_stat.done) begin
        got_max <= 1'b1;
      end
      if (min_stat.done) begin
        got_min <= 1'b1;
      end
      unique case (tstate)
        TS_IDLE: begin
          if (start) begin
            got_max <= 1'b0;
            got_min <= 1'b0;
            tstate  <= TS_RUN;
          end
        end
        TS_RUN: begin
          if (got_max && got_min) begin
            tstate <= TS_OUT;
          end
        end
        TS_OUT: begin
          if (out_free) begin
            best     <= best_next;
            m_tvalid <= 1'b1;
            tstate   <= TS_IDLE;
          end
        end
        default: begin
          tstate <= TS_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      item_first <= q_item.first;
      item_last  <= q_item.last;
    end
    if (max_stat.done) begin
      max_val <= max_stat.value;
    end
    if (min_stat.done) begin
      min_val <= min_stat.value;
    end
    if (tstate == TS_RUN) begin
      // Biased values share one offset, so their difference is the true spread.
      spread <= OUT_W'(max_val - min_val);
    end
    if ((tstate == TS_OUT) && out_free) begin
      m_tdata <= best_next;
      m_tlast <= item_last;
    end
  end

endmodule

// ===== hw/rtl/swmr_checker.sv =====
// Port-level checker for sliding_window_max_range, bound to the top level.
// Depends on swmr_pkg and the top level's ports.
module swmr_checker import swmr_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             s_tvalid,
  input logic             s_tready,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata,
  input logic             m_tlast
);

  // Queue slots plus the request in the back end plus the output register.
  localparam int PEND_MAX = QUEUE_DEPTH + 2;

  logic [QCNT_W:0] pending;
  logic            in_acc;
  logic            out_acc;

  assign in_acc  = s_tvalid && s_tready;
  assign out_acc = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      case ({in_acc, out_acc})
        2'b10:   pending <= pending + 1'b1;
        2'b01:   pending <= pending - 1'b1;
        default: pending <= pending;
      endcase
    end
  end

  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result offered right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result changed or dropped");

  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> pending != '0)
    else $error("result offered with no request outstanding");

  a_bound: assert property (@(posedge clk) disable iff (rst)
    pending <= (QCNT_W+1)'(PEND_MAX))
    else $error("more requests outstanding than the block can hold");

endmodule

bind sliding_window_max_range swmr_checker u_swmr_checker (.*);
